// ===== design/ttmc_pkg.sv =====
// shared constants, types and register codes for the touch trimmed-mean calibrator
package ttmc_pkg;

  // raw sample and collection
  localparam int RAW_W    = 12;
  localparam int RAW_MAX  = 4095;
  localparam int SAMPLES  = 5;
  localparam int COUNT_W  = $clog2(SAMPLES);
  localparam int TOTAL_W  = $clog2(SAMPLES * (RAW_MAX + 1));

  // trimmed mean by reciprocal multiply
  localparam int TRIM_DIV    = SAMPLES - 2;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int MEAN_RECIP  = (1 << RECIP_SHIFT) / TRIM_DIV;

  // screen and mapping arithmetic
  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;
  localparam int SCREEN_MAX    = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int TGT_W         = $clog2(SCREEN_MAX + 1);
  localparam int OFS_W         = RAW_W + 1;
  localparam int PROD_W        = OFS_W + TGT_W + 1;
  localparam int MAG_W         = PROD_W - 1;
  localparam int V_W           = PROD_W + 1;
  localparam int SX_W          = $clog2(SCREEN_WIDTH);
  localparam int SY_W          = $clog2(SCREEN_HEIGHT);

  // stream payload
  localparam int IN_DATA_W  = 2 * RAW_W;
  localparam int OUT_FLD_W  = 2 * RAW_W + SX_W + SY_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int REG_W  = 3;
  localparam logic [REG_W-1:0] REG_X_LOW  = 3'd0;
  localparam logic [REG_W-1:0] REG_X_HIGH = 3'd1;
  localparam logic [REG_W-1:0] REG_Y_LOW  = 3'd2;
  localparam logic [REG_W-1:0] REG_Y_HIGH = 3'd3;
  localparam logic [REG_W-1:0] REG_SWAP   = 3'd4;
  localparam logic [REG_W-1:0] REG_FLIP_X = 3'd5;
  localparam logic [REG_W-1:0] REG_FLIP_Y = 3'd6;

  // per-axis calibration handed to one lane
  typedef struct packed {
    logic [RAW_W-1:0] low;
    logic [RAW_W-1:0] high;
    logic [TGT_W-1:0] target;
    logic             flip;
  } axis_cfg_t;

  // sequencing from the top level to a lane
  typedef struct packed {
    logic start;
    logic take;
  } lane_ctl_t;

  // what a lane hands to the merge stage
  typedef struct packed {
    logic                  done;
    logic [RAW_W-1:0]      mean;
    logic signed [V_W-1:0] v;
  } lane_res_t;

endpackage

// ===== design/ttmc_accum.sv =====
// per-axis running sum, minimum and maximum over pen-down samples
module ttmc_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          add,
  input  logic                          clear,
  input  logic [ttmc_pkg::RAW_W-1:0]    sample,
  output logic [ttmc_pkg::TOTAL_W-1:0]  trim
);

  logic [ttmc_pkg::TOTAL_W-1:0] total;
  logic [ttmc_pkg::RAW_W-1:0]   least;
  logic [ttmc_pkg::RAW_W-1:0]   most;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      total <= '0;
      least <= ttmc_pkg::RAW_W'(ttmc_pkg::RAW_MAX);
      most  <= '0;
    end else if (add) begin
      total <= total + ttmc_pkg::TOTAL_W'(sample);
      if (sample < least) least <= sample;
      if (sample > most) most <= sample;
    end
  end

  // sum with the extremes removed
  assign trim = total - ttmc_pkg::TOTAL_W'(least) - ttmc_pkg::TOTAL_W'(most);

endmodule

// ===== design/ttmc_divider.sv =====
// restoring unsigned divider, one quotient bit per cycle
module ttmc_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ttmc_pkg::MAG_W-1:0]  dividend,
  input  logic [ttmc_pkg::RAW_W-1:0]  divisor,
  output logic                        done,
  output logic [ttmc_pkg::MAG_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(ttmc_pkg::MAG_W + 1);

  logic [ttmc_pkg::RAW_W-1:0] rem;
  logic [ttmc_pkg::RAW_W-1:0] dvs;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [ttmc_pkg::RAW_W:0]   shifted;
  logic                       ge;
  logic [ttmc_pkg::RAW_W:0]   diff;

  assign shifted = {rem, quotient[ttmc_pkg::MAG_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ttmc_pkg::MAG_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[ttmc_pkg::RAW_W-1:0] : shifted[ttmc_pkg::RAW_W-1:0];
      quotient <= {quotient[ttmc_pkg::MAG_W-2:0], ge};
    end
  end

endmodule

// ===== design/ttmc_scale.sv =====
// one axis lane: trimmed mean, linear map through a signed divide, optional mirror
module ttmc_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  ttmc_pkg::lane_ctl_t           ctl,
  input  ttmc_pkg::axis_cfg_t           cfg,
  input  logic [ttmc_pkg::TOTAL_W-1:0]  trim,
  output ttmc_pkg::lane_res_t           res
);

  localparam logic [2:0] SC_IDLE  = 3'd0;
  localparam logic [2:0] SC_RECIP = 3'd1;
  localparam logic [2:0] SC_MEAN  = 3'd2;
  localparam logic [2:0] SC_PROD  = 3'd3;
  localparam logic [2:0] SC_DIV   = 3'd4;
  localparam logic [2:0] SC_WAIT  = 3'd5;
  localparam logic [2:0] SC_DONE  = 3'd6;

  localparam int RMUL_W = ttmc_pkg::TOTAL_W + ttmc_pkg::RECIP_W;

  logic [2:0]                          state;
  logic [ttmc_pkg::TOTAL_W-1:0]        trim_r;
  logic [RMUL_W-1:0]                   rmul;
  logic [ttmc_pkg::RAW_W-1:0]          q_est;
  logic [ttmc_pkg::TOTAL_W-1:0]        resid;
  logic [ttmc_pkg::RAW_W-1:0]          mean;
  logic signed [ttmc_pkg::OFS_W-1:0]   ofs;
  logic signed [ttmc_pkg::OFS_W-1:0]   rng;
  logic signed [ttmc_pkg::PROD_W-1:0]  prod_now;
  logic [ttmc_pkg::MAG_W-1:0]          prod_mag;
  logic [ttmc_pkg::RAW_W-1:0]          rng_mag;
  logic                                neg;
  logic                                div_done;
  logic [ttmc_pkg::MAG_W-1:0]          quo;
  logic signed [ttmc_pkg::V_W-1:0]     q_signed;
  logic signed [ttmc_pkg::V_W-1:0]     v_mapped;
  logic signed [ttmc_pkg::V_W-1:0]     v;

  // floor(trim / TRIM_DIV) via reciprocal, at most one short
  assign rmul  = RMUL_W'(trim_r) * RMUL_W'(ttmc_pkg::MEAN_RECIP);
  assign resid = trim_r - ttmc_pkg::TOTAL_W'(q_est) * ttmc_pkg::TOTAL_W'(ttmc_pkg::TRIM_DIV);

  assign ofs = $signed({1'b0, mean}) - $signed({1'b0, cfg.low});
  assign rng = $signed({1'b0, cfg.high}) - $signed({1'b0, cfg.low});
  assign prod_now = ttmc_pkg::PROD_W'(ofs) * $signed(ttmc_pkg::PROD_W'(cfg.target));

  always_comb begin
    q_signed = $signed({2'b00, quo});
    if (neg) q_signed = -q_signed;
    if (cfg.flip) begin
      v_mapped = $signed(ttmc_pkg::V_W'(cfg.target)) - ttmc_pkg::V_W'(1) - q_signed;
    end else begin
      v_mapped = q_signed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      case (state)
        SC_IDLE:  if (ctl.start) state <= SC_RECIP;
        SC_RECIP: state <= SC_MEAN;
        SC_MEAN:  state <= SC_PROD;
        SC_PROD:  state <= SC_DIV;
        SC_DIV:   state <= SC_WAIT;
        SC_WAIT:  if (div_done) state <= SC_DONE;
        SC_DONE:  if (ctl.take) state <= SC_IDLE;
        default:  state <= SC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == SC_IDLE && ctl.start) trim_r <= trim;
    if (state == SC_RECIP) begin
      q_est <= rmul[ttmc_pkg::RECIP_SHIFT +: ttmc_pkg::RAW_W];
    end
    if (state == SC_MEAN) begin
      mean <= (resid >= ttmc_pkg::TOTAL_W'(ttmc_pkg::TRIM_DIV)) ? q_est + 1'b1 : q_est;
    end
    if (state == SC_PROD) begin
      // zero range counts as one
      prod_mag <= prod_now[ttmc_pkg::PROD_W-1] ? ttmc_pkg::MAG_W'(-prod_now)
                                               : ttmc_pkg::MAG_W'(prod_now);
      if (rng == '0) begin
        rng_mag <= ttmc_pkg::RAW_W'(1);
      end else if (rng[ttmc_pkg::OFS_W-1]) begin
        rng_mag <= ttmc_pkg::RAW_W'(-rng);
      end else begin
        rng_mag <= ttmc_pkg::RAW_W'(rng);
      end
      neg <= prod_now[ttmc_pkg::PROD_W-1] ^ rng[ttmc_pkg::OFS_W-1];
    end
    if (state == SC_WAIT && div_done) v <= v_mapped;
  end

  ttmc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == SC_DIV),
    .dividend (prod_mag),
    .divisor  (rng_mag),
    .done     (div_done),
    .quotient (quo)
  );

  assign res.done = (state == SC_DONE);
  assign res.mean = mean;
  assign res.v    = v;

endmodule

// ===== design/ttmc_merge.sv =====
// joins both lanes: axis swap, clamp to the screen, output register
module ttmc_merge (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load_res,
  input  logic                                 load_zero,
  input  logic                                 swap,
  input  ttmc_pkg::lane_res_t                  res_x,
  input  ttmc_pkg::lane_res_t                  res_y,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output logic [ttmc_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tuser
);

  logic [ttmc_pkg::SX_W-1:0]  scr_x;
  logic [ttmc_pkg::SY_W-1:0]  scr_y;
  logic signed [ttmc_pkg::V_W-1:0] src_x;
  logic signed [ttmc_pkg::V_W-1:0] src_y;

  assign src_x = swap ? res_y.v : res_x.v;
  assign src_y = swap ? res_x.v : res_y.v;

  always_comb begin
    if (src_x < 0) begin
      scr_x = '0;
    end else if (src_x >= ttmc_pkg::V_W'(ttmc_pkg::SCREEN_WIDTH)) begin
      scr_x = ttmc_pkg::SX_W'(ttmc_pkg::SCREEN_WIDTH - 1);
    end else begin
      scr_x = src_x[ttmc_pkg::SX_W-1:0];
    end
    if (src_y < 0) begin
      scr_y = '0;
    end else if (src_y >= ttmc_pkg::V_W'(ttmc_pkg::SCREEN_HEIGHT)) begin
      scr_y = ttmc_pkg::SY_W'(ttmc_pkg::SCREEN_HEIGHT - 1);
    end else begin
      scr_y = src_y[ttmc_pkg::SY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_res || load_zero) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      m_tuser <= 1'b1;
      m_tdata <= ttmc_pkg::OUT_DATA_W'({scr_y, scr_x, res_y.mean, res_x.mean});
    end else if (load_zero) begin
      m_tuser <= 1'b0;
      m_tdata <= '0;
    end
  end

endmodule

// ===== design/touch_trimmed_mean_calibrate.sv =====
// top level: resistive touch trimmed-mean filter with linear screen calibration
//
//  channel   dir  handshake         payload
//  s_*       in   tvalid/tready     tdata: sample_x[11:0], sample_y[23:12]; tuser: pen_down
//  m_*       out  tvalid/tready     tdata: mean_x, mean_y, screen_x, screen_y; tuser: touched
//  apb       in   psel/penable      7 registers at byte address 4*i, pready always high
//
//  a pen-down item that does not complete the set is only added to the collection
//  the item that completes the set starts both axis lanes, and no input is taken
//    until the result leaves; each lane holds a bit-serial divider
//  pen-up items are answered with a no-contact result; an item is taken only when the
//    output register is empty or being emptied in the same cycle
//  rst is synchronous and clears the collection and registers to defaults
module touch_trimmed_mean_calibrate (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ttmc_pkg::IN_DATA_W-1:0]      s_tdata,   // sample_x, sample_y
  input  logic                                s_tuser,   // pen_down
  // result items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ttmc_pkg::OUT_DATA_W-1:0]     m_tdata,   // mean_x, mean_y, screen_x, screen_y, zero pad
  output logic                                m_tuser,   // touched
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ttmc_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_START   = 2'd1;
  localparam logic [1:0] ST_CALC    = 2'd2;

  // configuration registers
  logic [ttmc_pkg::RAW_W-1:0] x_raw_low;
  logic [ttmc_pkg::RAW_W-1:0] x_raw_high;
  logic [ttmc_pkg::RAW_W-1:0] y_raw_low;
  logic [ttmc_pkg::RAW_W-1:0] y_raw_high;
  logic                       swap_axes;
  logic                       flip_x;
  logic                       flip_y;

  logic [1:0]                     state;
  logic [ttmc_pkg::COUNT_W-1:0]   pair_count;
  logic                           accept;
  logic                           pen_down;
  logic                           last_pair;
  logic                           out_free;
  logic                           load_res;
  logic                           load_zero;
  logic                           cfg_wr;
  logic [ttmc_pkg::REG_W-1:0]     reg_idx;
  logic [ttmc_pkg::TOTAL_W-1:0]   trim_x;
  logic [ttmc_pkg::TOTAL_W-1:0]   trim_y;
  ttmc_pkg::lane_ctl_t            ctl;
  ttmc_pkg::axis_cfg_t            cfg_x;
  ttmc_pkg::axis_cfg_t            cfg_y;
  ttmc_pkg::lane_res_t            res_x;
  ttmc_pkg::lane_res_t            res_y;

  // apb register file, writes land on the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[ttmc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_raw_low  <= '0;
      x_raw_high <= ttmc_pkg::RAW_W'(ttmc_pkg::RAW_MAX);
      y_raw_low  <= '0;
      y_raw_high <= ttmc_pkg::RAW_W'(ttmc_pkg::RAW_MAX);
      swap_axes  <= 1'b0;
      flip_x     <= 1'b0;
      flip_y     <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        ttmc_pkg::REG_X_LOW:  x_raw_low  <= pwdata[ttmc_pkg::RAW_W-1:0];
        ttmc_pkg::REG_X_HIGH: x_raw_high <= pwdata[ttmc_pkg::RAW_W-1:0];
        ttmc_pkg::REG_Y_LOW:  y_raw_low  <= pwdata[ttmc_pkg::RAW_W-1:0];
        ttmc_pkg::REG_Y_HIGH: y_raw_high <= pwdata[ttmc_pkg::RAW_W-1:0];
        ttmc_pkg::REG_SWAP:   swap_axes  <= pwdata[0];
        ttmc_pkg::REG_FLIP_X: flip_x     <= pwdata[0];
        ttmc_pkg::REG_FLIP_Y: flip_y     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ttmc_pkg::REG_X_LOW:  prdata = 32'(x_raw_low);
      ttmc_pkg::REG_X_HIGH: prdata = 32'(x_raw_high);
      ttmc_pkg::REG_Y_LOW:  prdata = 32'(y_raw_low);
      ttmc_pkg::REG_Y_HIGH: prdata = 32'(y_raw_high);
      ttmc_pkg::REG_SWAP:   prdata = 32'(swap_axes);
      ttmc_pkg::REG_FLIP_X: prdata = 32'(flip_x);
      ttmc_pkg::REG_FLIP_Y: prdata = 32'(flip_y);
      default:              prdata = '0;
    endcase
  end

  // input handshake: only while collecting and with room for a result
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_COLLECT) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign pen_down  = s_tuser;
  assign last_pair = (pair_count == ttmc_pkg::COUNT_W'(ttmc_pkg::SAMPLES - 1));

  // both lanes finish together; the result leaves once the output slot is free
  assign load_res  = (state == ST_CALC) && res_x.done && res_y.done && out_free;
  assign load_zero = accept && !pen_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      pair_count <= '0;
    end else begin
      case (state)
        ST_COLLECT: begin
          if (accept) begin
            if (!pen_down || last_pair) begin
              pair_count <= '0;
            end else begin
              pair_count <= pair_count + 1'b1;
            end
            if (pen_down && last_pair) state <= ST_START;
          end
        end
        ST_START: state <= ST_CALC;
        ST_CALC:  if (load_res) state <= ST_COLLECT;
        default:  state <= ST_COLLECT;
      endcase
    end
  end

  assign ctl.start = (state == ST_START);
  assign ctl.take  = load_res;

  // target dimension follows the swap: raw x drives screen y when swapped
  assign cfg_x.low    = x_raw_low;
  assign cfg_x.high   = x_raw_high;
  assign cfg_x.target = swap_axes ? ttmc_pkg::TGT_W'(ttmc_pkg::SCREEN_HEIGHT)
                                  : ttmc_pkg::TGT_W'(ttmc_pkg::SCREEN_WIDTH);
  assign cfg_x.flip   = flip_x;
  assign cfg_y.low    = y_raw_low;
  assign cfg_y.high   = y_raw_high;
  assign cfg_y.target = swap_axes ? ttmc_pkg::TGT_W'(ttmc_pkg::SCREEN_WIDTH)
                                  : ttmc_pkg::TGT_W'(ttmc_pkg::SCREEN_HEIGHT);
  assign cfg_y.flip   = flip_y;

  // x lane
  ttmc_accum u_acc_x (
    .clk    (clk),
    .rst    (rst),
    .add    (accept && pen_down),
    .clear  (load_zero || load_res),
    .sample (s_tdata[ttmc_pkg::RAW_W-1:0]),
    .trim   (trim_x)
  );

  ttmc_scale u_lane_x (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .cfg  (cfg_x),
    .trim (trim_x),
    .res  (res_x)
  );

  // y lane
  ttmc_accum u_acc_y (
    .clk    (clk),
    .rst    (rst),
    .add    (accept && pen_down),
    .clear  (load_zero || load_res),
    .sample (s_tdata[2*ttmc_pkg::RAW_W-1:ttmc_pkg::RAW_W]),
    .trim   (trim_y)
  );

  ttmc_scale u_lane_y (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .cfg  (cfg_y),
    .trim (trim_y),
    .res  (res_y)
  );

  ttmc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load_res  (load_res),
    .load_zero (load_zero),
    .swap      (swap_axes),
    .res_x     (res_x),
    .res_y     (res_y),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // lanes run in lockstep
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    res_x.done == res_y.done)
    else $error("axis lanes out of step");

  // a no-contact result carries all-zero fields
  a_untouched_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("no-contact result with nonzero fields");

  // the collection restarts when a set is handed to the lanes
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    (state == ST_START) |-> (pair_count == '0))
    else $error("pair count not cleared at set completion");

  // no input is taken while a set is being computed
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_COLLECT) |-> !s_tready)
    else $error("input taken during computation");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the touch trimmed-mean calibrator
module tb;

  // one result item as it leaves the block, fields unpacked
  typedef struct packed {
    logic                       touched;
    logic [ttmc_pkg::RAW_W-1:0] mean_x;
    logic [ttmc_pkg::RAW_W-1:0] mean_y;
    logic [ttmc_pkg::SX_W-1:0]  screen_x;
    logic [ttmc_pkg::SY_W-1:0]  screen_y;
  } touch_point_t;

  // bit positions of the result fields inside m_tdata
  localparam int MEAN_Y_LO   = ttmc_pkg::RAW_W;
  localparam int SCREEN_X_LO = 2 * ttmc_pkg::RAW_W;
  localparam int SCREEN_Y_LO = SCREEN_X_LO + ttmc_pkg::SX_W;

  // register index past the end of the list, writes to it must do nothing
  localparam logic [ttmc_pkg::REG_W-1:0] REG_SPARE = 3'd7;

  // time for the axis dividers to finish, with margin
  localparam int SETTLE_CYCLES = 48;
  localparam int ITEM_TARGET   = 1850;
  localparam int DIRECTED_LEN  = 25;
  localparam int RANDOM_PHASES = 12;

  // ---------------------------------------------------------------------------
  // predictor and store of expected points
  // ---------------------------------------------------------------------------
  class touch_scoreboard;
    logic [ttmc_pkg::RAW_W-1:0] x_low, x_high, y_low, y_high;
    logic                       swap_xy, mirror_x, mirror_y;
    int                         pairs, x_sum, y_sum;
    logic [ttmc_pkg::RAW_W-1:0] x_min, x_max, y_min, y_max;
    touch_point_t               pending_q[$];
    int                         errors;

    function new();
      x_low   = '0;
      x_high  = ttmc_pkg::RAW_W'(ttmc_pkg::RAW_MAX);
      y_low   = '0;
      y_high  = ttmc_pkg::RAW_W'(ttmc_pkg::RAW_MAX);
      swap_xy = 1'b0;
      mirror_x = 1'b0;
      mirror_y = 1'b0;
      errors  = 0;
      restart_set();
    endfunction

    function void restart_set();
      pairs = 0;
      x_sum = 0;
      y_sum = 0;
      x_min = ttmc_pkg::RAW_W'(ttmc_pkg::RAW_MAX);
      x_max = '0;
      y_min = ttmc_pkg::RAW_W'(ttmc_pkg::RAW_MAX);
      y_max = '0;
    endfunction

    // register write as the block sees it: upper bits dropped
    function void write_cal(logic [ttmc_pkg::REG_W-1:0] idx, logic [31:0] word);
      case (idx)
        ttmc_pkg::REG_X_LOW:  x_low    = word[ttmc_pkg::RAW_W-1:0];
        ttmc_pkg::REG_X_HIGH: x_high   = word[ttmc_pkg::RAW_W-1:0];
        ttmc_pkg::REG_Y_LOW:  y_low    = word[ttmc_pkg::RAW_W-1:0];
        ttmc_pkg::REG_Y_HIGH: y_high   = word[ttmc_pkg::RAW_W-1:0];
        ttmc_pkg::REG_SWAP:   swap_xy  = word[0];
        ttmc_pkg::REG_FLIP_X: mirror_x = word[0];
        ttmc_pkg::REG_FLIP_Y: mirror_y = word[0];
        default: ;
      endcase
    endfunction

    // offset times target over range, signed and truncated toward zero
    function int scale_to_screen(int mean, int lo, int hi, int target, logic mirror);
      int span;
      int pos;
      span = hi - lo;
      if (span == 0) span = 1;
      pos = ((mean - lo) * target) / span;
      if (mirror) pos = target - 1 - pos;
      return pos;
    endfunction

    function int limit_to(int pos, int n);
      if (pos < 0) return 0;
      if (pos >= n) return n - 1;
      return pos;
    endfunction

    function void note_item(logic [ttmc_pkg::RAW_W-1:0] sx, logic [ttmc_pkg::RAW_W-1:0] sy,
                            logic pen);
      touch_point_t pt;
      int mx, my, tgt_x, tgt_y, vx, vy, col, row;
      pt = '0;
      // lifting the pen throws the set away and reports no contact
      if (!pen) begin
        restart_set();
        pending_q.push_back(pt);
        return;
      end
      x_sum += int'(sx);
      y_sum += int'(sy);
      if (sx < x_min) x_min = sx;
      if (sx > x_max) x_max = sx;
      if (sy < y_min) y_min = sy;
      if (sy > y_max) y_max = sy;
      pairs++;
      if (pairs < ttmc_pkg::SAMPLES) return;

      // trimmed mean: drop one lowest and one highest sample per axis
      mx = (x_sum - int'(x_min) - int'(x_max)) / (ttmc_pkg::SAMPLES - 2);
      my = (y_sum - int'(y_min) - int'(y_max)) / (ttmc_pkg::SAMPLES - 2);
      restart_set();

      tgt_x = swap_xy ? ttmc_pkg::SCREEN_HEIGHT : ttmc_pkg::SCREEN_WIDTH;
      tgt_y = swap_xy ? ttmc_pkg::SCREEN_WIDTH : ttmc_pkg::SCREEN_HEIGHT;
      vx = scale_to_screen(mx, int'(x_low), int'(x_high), tgt_x, mirror_x);
      vy = scale_to_screen(my, int'(y_low), int'(y_high), tgt_y, mirror_y);
      if (swap_xy) begin
        col = limit_to(vy, ttmc_pkg::SCREEN_WIDTH);
        row = limit_to(vx, ttmc_pkg::SCREEN_HEIGHT);
      end else begin
        col = limit_to(vx, ttmc_pkg::SCREEN_WIDTH);
        row = limit_to(vy, ttmc_pkg::SCREEN_HEIGHT);
      end
      pt.touched  = 1'b1;
      pt.mean_x   = mx[ttmc_pkg::RAW_W-1:0];
      pt.mean_y   = my[ttmc_pkg::RAW_W-1:0];
      pt.screen_x = col[ttmc_pkg::SX_W-1:0];
      pt.screen_y = row[ttmc_pkg::SY_W-1:0];
      pending_q.push_back(pt);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(touch_point_t got);
      touch_point_t want;
      if (pending_q.size() == 0) begin
        $error("result item with nothing expected: touched %0d screen %0d,%0d",
               got.touched, got.screen_x, got.screen_y);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      compare_field("touched",  want.touched,  got.touched);
      compare_field("mean_x",   want.mean_x,   got.mean_x);
      compare_field("mean_y",   want.mean_y,   got.mean_y);
      compare_field("screen_x", want.screen_x, got.screen_x);
      compare_field("screen_y", want.screen_y, got.screen_y);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, dut and its inputs
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [ttmc_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // sample_x, sample_y
  logic                            s_tuser = 1'b0; // pen_down
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ttmc_pkg::OUT_DATA_W-1:0] m_tdata;        // mean_x, mean_y, screen_x, screen_y, pad
  logic                            m_tuser;        // touched
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [ttmc_pkg::ADDR_W-1:0]     paddr = '0;
  logic [31:0]                     pwdata = '0;
  logic [31:0]                     prdata;
  logic                            pready;

  always #2 clk = ~clk;

  touch_trimmed_mean_calibrate u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  touch_scoreboard board = new();

  int items_sent = 0;
  int tx_gap_pct = 0;   // chance in percent of a sender gap before an item
  bit rx_calm    = 1'b1; // receiver never stalls while set
  int rx_stall   = 0;

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, checking at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_calm) begin
      m_tready <= 1'b1;
      rx_stall = 0;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin : result_monitor
    touch_point_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.touched  = m_tuser;
      got.mean_x   = m_tdata[ttmc_pkg::RAW_W-1:0];
      got.mean_y   = m_tdata[MEAN_Y_LO +: ttmc_pkg::RAW_W];
      got.screen_x = m_tdata[SCREEN_X_LO +: ttmc_pkg::SX_W];
      got.screen_y = m_tdata[SCREEN_Y_LO +: ttmc_pkg::SY_W];
      board.check_result(got);
    end
  end

  // ---------------------------------------------------------------------------
  // sample side and register port; all tasks start and end at a falling edge
  // ---------------------------------------------------------------------------

  // one sample pair; leaves tvalid high so back-to-back items need no gap
  task automatic send_item(input logic [ttmc_pkg::RAW_W-1:0] sx,
                           input logic [ttmc_pkg::RAW_W-1:0] sy, input logic pen);
    if (tx_gap_pct > 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sy, sx};
    s_tuser  <= pen;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(sx, sy, pen);
    items_sent++;
    @(negedge clk);
  endtask

  // stop sending, let every expected point arrive, then let the dividers go quiet
  task automatic wait_for_points();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ttmc_pkg::REG_W-1:0] idx, input logic [31:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.write_cal(idx, word);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // return to idle before the next transfer
    @(negedge clk);
  endtask

  // full calibration; junk in the unused upper bits must be ignored
  task automatic program_cal(input logic [ttmc_pkg::RAW_W-1:0] xl,
                             input logic [ttmc_pkg::RAW_W-1:0] xh,
                             input logic [ttmc_pkg::RAW_W-1:0] yl,
                             input logic [ttmc_pkg::RAW_W-1:0] yh,
                             input logic sw, input logic fx, input logic fy);
    logic [31:0] w [7];
    foreach (w[i]) w[i] = $urandom;
    w[0][ttmc_pkg::RAW_W-1:0] = xl;
    w[1][ttmc_pkg::RAW_W-1:0] = xh;
    w[2][ttmc_pkg::RAW_W-1:0] = yl;
    w[3][ttmc_pkg::RAW_W-1:0] = yh;
    w[4][0] = sw;
    w[5][0] = fx;
    w[6][0] = fy;
    write_reg(ttmc_pkg::REG_X_LOW,  w[0]);
    write_reg(ttmc_pkg::REG_X_HIGH, w[1]);
    write_reg(ttmc_pkg::REG_Y_LOW,  w[2]);
    write_reg(ttmc_pkg::REG_Y_HIGH, w[3]);
    write_reg(ttmc_pkg::REG_SWAP,   w[4]);
    write_reg(ttmc_pkg::REG_FLIP_X, w[5]);
    write_reg(ttmc_pkg::REG_FLIP_Y, w[6]);
    // past the register list, must leave everything as it was
    write_reg(REG_SPARE, $urandom);
    @(negedge clk);
  endtask

  function automatic logic [ttmc_pkg::RAW_W-1:0] raw_near(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > ttmc_pkg::RAW_MAX) v = ttmc_pkg::RAW_MAX;
    return v[ttmc_pkg::RAW_W-1:0];
  endfunction

  // a press: some full sets around one spot, maybe a torn set, then a lift
  task automatic press(input int sets, input bit torn);
    int cx, cy, spread;
    cx = $urandom_range(0, ttmc_pkg::RAW_MAX);
    cy = $urandom_range(0, ttmc_pkg::RAW_MAX);
    // mostly a steady finger, sometimes pure noise across the panel
    spread = ($urandom_range(0, 4) == 0) ? 2048 : $urandom_range(0, 60);
    repeat (sets * ttmc_pkg::SAMPLES)
      send_item(raw_near(cx, spread), raw_near(cy, spread), 1'b1);
    if (torn)
      repeat ($urandom_range(1, ttmc_pkg::SAMPLES - 1))
        send_item(raw_near(cx, spread), raw_near(cy, spread), 1'b1);
    send_item(raw_near(cx, 2048), raw_near(cy, 2048), 1'b0);
  endtask

  // 12-bit calibration end points, normal, reversed, degenerate or arbitrary
  task automatic pick_span(output logic [ttmc_pkg::RAW_W-1:0] lo,
                           output logic [ttmc_pkg::RAW_W-1:0] hi);
    int a, b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        a = $urandom_range(0, 600);
        b = $urandom_range(3400, ttmc_pkg::RAW_MAX);
      end
      4, 5: begin
        a = $urandom_range(3400, ttmc_pkg::RAW_MAX);
        b = $urandom_range(0, 600);
      end
      6: begin
        a = $urandom_range(0, ttmc_pkg::RAW_MAX);
        b = a;
      end
      7: begin
        a = 0;
        b = ttmc_pkg::RAW_MAX;
      end
      default: begin
        a = $urandom_range(0, ttmc_pkg::RAW_MAX);
        b = $urandom_range(0, ttmc_pkg::RAW_MAX);
      end
    endcase
    lo = a[ttmc_pkg::RAW_W-1:0];
    hi = b[ttmc_pkg::RAW_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [ttmc_pkg::RAW_W-1:0] xl, xh, yl, yh;
    logic sw, fx, fy;
    int   goal;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset calibration: lift with extreme samples, all-zero set,
    // all-full-scale set (clamps at the far edge), torn set then lift
    send_item(12'h000, 12'hFFF, 1'b0);
    repeat (ttmc_pkg::SAMPLES) send_item(12'h000, 12'h000, 1'b1);
    repeat (ttmc_pkg::SAMPLES) send_item(12'hFFF, 12'hFFF, 1'b1);
    send_item(12'hABC, 12'h543, 1'b1);
    send_item(12'h5A5, 12'hA5A, 1'b1);
    send_item(12'h3C3, 12'hC3C, 1'b1);
    send_item(12'h800, 12'h7FF, 1'b0);
    wait_for_points();

    // directed: zero range on x, reversed range on y, swap and both mirrors
    program_cal(12'd2048, 12'd2048, 12'hFFF, 12'h000, 1'b1, 1'b1, 1'b1);
    send_item(12'h000, 12'h800, 1'b1);
    send_item(12'hFFF, 12'h801, 1'b1);
    send_item(12'd1000, 12'h7FF, 1'b1);
    send_item(12'd3000, 12'h800, 1'b1);
    send_item(12'd2048, 12'h802, 1'b1);
    repeat (ttmc_pkg::SAMPLES) send_item(12'd2050, 12'd100, 1'b1);
    wait_for_points();

    // random phases, each with its own calibration and idling mix
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick_span(xl, xh);
      pick_span(yl, yh);
      if (ph < 8) begin
        // walk all swap and mirror combinations first
        sw = ph[0];
        fx = ph[1];
        fy = ph[2];
      end else begin
        sw = $urandom_range(0, 1);
        fx = $urandom_range(0, 1);
        fy = $urandom_range(0, 1);
      end
      program_cal(xl, xh, yl, yh, sw, fx, fy);

      // last phase runs flat out on both sides
      if (ph == RANDOM_PHASES - 1) begin
        tx_gap_pct = 0;
        rx_calm    = 1'b1;
      end else begin
        case ($urandom_range(0, 2))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 8;
          default: tx_gap_pct = 30;
        endcase
        rx_calm = ($urandom_range(0, 3) == 0);
      end

      goal = DIRECTED_LEN + (ph + 1) * (ITEM_TARGET - DIRECTED_LEN) / RANDOM_PHASES;
      while (items_sent < goal) begin
        press($urandom_range(1, 4), $urandom_range(0, 3) == 0);
        // mid-phase hold-off until the output side has caught up
        if (ph == 4 && $urandom_range(0, 5) == 0) wait_for_points();
      end
      wait_for_points();
    end

    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("touch_trimmed_mean_calibrate test passed");
    end else begin
      $display("touch_trimmed_mean_calibrate test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("touch_trimmed_mean_calibrate test failed");
    $finish;
  end

endmodule

// ===== touch_trimmed_mean_calibrate.f =====
design/ttmc_pkg.sv
design/ttmc_accum.sv
design/ttmc_divider.sv
design/ttmc_scale.sv
design/ttmc_merge.sv
design/touch_trimmed_mean_calibrate.sv
tb/tb.sv
